FILE: hdl/pbd_pkg.sv
package pbd_pkg;

  // Default coordinate width and the CORDIC arrangement.
  localparam int COORD_BITS_DEF  = 10;
  localparam int PRE_SHIFT       = 24;
  localparam int CORDIC_GUARD    = 3;
  localparam int CORDIC_EXTRA    = PRE_SHIFT + CORDIC_GUARD;
  localparam int CORDIC_STEPS    = 24;
  localparam int STEPS_PER_STAGE = 2;
  localparam int CORDIC_STAGES   = CORDIC_STEPS / STEPS_PER_STAGE;

  // Angle accumulator: signed radians in Q30.
  localparam int ZW       = 32;
  localparam int ANG_W    = 31;
  localparam int FRAC_Q   = 30;
  localparam int ATAN_W   = 30;

  // Scale, fold and rounding constants, all in tenths of a degree at Q30.
  localparam int SCALE_W  = 10;
  localparam logic [SCALE_W-1:0] SCALE_TENTHS = 10'd573;
  localparam int PROD_W   = ANG_W + SCALE_W;
  localparam int FOLD_W   = 42;
  localparam logic [FOLD_W-1:0] HALF_Q     = 42'd5 << 29;
  localparam logic [FOLD_W-1:0] FOLD_180_Q = 42'd1800 << FRAC_Q;
  localparam logic [FOLD_W-1:0] FOLD_360_Q = 42'd3600 << FRAC_Q;

  // Whole tenths after the Q30 shift, then divide by ten with a reciprocal.
  localparam int TENTHS_W = FOLD_W - FRAC_Q;
  localparam int RECIP_W  = 13;
  localparam logic [RECIP_W-1:0] DIV10_RECIP = 13'd6554;
  localparam int DIV10_SHIFT = 16;
  localparam int DIVP_W   = TENTHS_W + RECIP_W;
  localparam int BEARING_W = 9;

  // atan(2^-i) in Q30, truncated.
  localparam logic [ATAN_W-1:0] ATAN_LUT [CORDIC_STEPS] = '{
    30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6,
    30'h03FEAB76, 30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55,
    30'h003FFFEA, 30'h001FFFFD, 30'h000FFFFF, 30'h0007FFFF,
    30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF, 30'h00007FFF,
    30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
    30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F
  };

  // Geometry of the point pair that travels beside the CORDIC data.
  typedef struct packed {
    logic same;     // both points coincide
    logic dx_zero;  // pure vertical offset
    logic right;    // target lies right of the observer
    logic up;       // target lies above the observer
  } flags_t;

endpackage

FILE: hdl/pbd_ifs.sv
interface pbd_in_if #(
  parameter int COORD_BITS = pbd_pkg::COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] from_x;
  logic [COORD_BITS-1:0] from_y;
  logic [COORD_BITS-1:0] to_x;
  logic [COORD_BITS-1:0] to_y;

  modport source (output valid, from_x, from_y, to_x, to_y, input ready);
  modport sink   (input valid, from_x, from_y, to_x, to_y, output ready);
endinterface

interface pbd_out_if;
  logic                              valid;
  logic                              ready;
  logic [pbd_pkg::BEARING_W-1:0]     bearing_deg;
  logic                              same_point;

  modport source (output valid, bearing_deg, same_point, input ready);
  modport sink   (input valid, bearing_deg, same_point, output ready);
endinterface

FILE: hdl/pbd_front.sv
module pbd_front #(
  parameter int COORD_BITS = pbd_pkg::COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_BITS-1:0] from_x,
  input  logic [COORD_BITS-1:0] from_y,
  input  logic [COORD_BITS-1:0] to_x,
  input  logic [COORD_BITS-1:0] to_y,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [COORD_BITS+pbd_pkg::CORDIC_EXTRA-1:0] out_cx,
  output logic signed [COORD_BITS+pbd_pkg::CORDIC_EXTRA-1:0] out_cy,
  output pbd_pkg::flags_t       out_flags
);
  import pbd_pkg::*;

  localparam int CW = COORD_BITS + CORDIC_EXTRA;
  localparam logic [PRE_SHIFT-1:0] ZPAD = '0;

  logic [COORD_BITS-1:0] adx_nxt, ady_nxt, adx_r, ady_r;
  flags_t                flags_nxt, flags_r;
  logic                  valid_r;

  // Absolute offsets and the quadrant of the target.
  always_comb begin
    adx_nxt           = (from_x > to_x) ? (from_x - to_x) : (to_x - from_x);
    ady_nxt           = (from_y > to_y) ? (from_y - to_y) : (to_y - from_y);
    flags_nxt.same    = (from_x == to_x) && (from_y == to_y);
    flags_nxt.dx_zero = (from_x == to_x);
    flags_nxt.right   = (from_x < to_x);
    flags_nxt.up      = (from_y > to_y);
  end

  assign in_ready = !valid_r || out_ready;

  // Valid bit of the stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // Payload of the stage.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      adx_r   <= adx_nxt;
      ady_r   <= ady_nxt;
      flags_r <= flags_nxt;
    end
  end

  // The CORDIC starts from x = |dy| and y = |dx|, both pre-scaled.
  assign out_valid = valid_r;
  assign out_cx    = signed'(CW'({ady_r, ZPAD}));
  assign out_cy    = signed'(CW'({adx_r, ZPAD}));
  assign out_flags = flags_r;

endmodule

FILE: hdl/pbd_cordic_stage.sv
module pbd_cordic_stage #(
  parameter int COORD_BITS = pbd_pkg::COORD_BITS_DEF,
  parameter int FIRST      = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [COORD_BITS+pbd_pkg::CORDIC_EXTRA-1:0] in_cx,
  input  logic signed [COORD_BITS+pbd_pkg::CORDIC_EXTRA-1:0] in_cy,
  input  logic signed [pbd_pkg::ZW-1:0] in_z,
  input  pbd_pkg::flags_t       in_flags,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [COORD_BITS+pbd_pkg::CORDIC_EXTRA-1:0] out_cx,
  output logic signed [COORD_BITS+pbd_pkg::CORDIC_EXTRA-1:0] out_cy,
  output logic signed [pbd_pkg::ZW-1:0] out_z,
  output pbd_pkg::flags_t       out_flags
);
  import pbd_pkg::*;

  localparam int CW = COORD_BITS + CORDIC_EXTRA;

  logic signed [CW-1:0] cx_nxt, cy_nxt, cx_r, cy_r;
  logic signed [ZW-1:0] z_nxt, z_r;
  flags_t               flags_r;
  logic                 valid_r;

  // Vectoring micro-rotations; the arithmetic shift rounds toward minus infinity.
  always_comb begin
    logic signed [CW-1:0] sx, sy;
    logic signed [ZW-1:0] ang;
    cx_nxt = in_cx;
    cy_nxt = in_cy;
    z_nxt  = in_z;
    for (int k = 0; k < STEPS_PER_STAGE; k++) begin
      sx  = cx_nxt >>> (FIRST + k);
      sy  = cy_nxt >>> (FIRST + k);
      ang = signed'(ZW'(ATAN_LUT[FIRST + k]));
      if (!cy_nxt[CW-1]) begin
        cx_nxt = cx_nxt + sy;
        cy_nxt = cy_nxt - sx;
        z_nxt  = z_nxt + ang;
      end else begin
        cx_nxt = cx_nxt - sy;
        cy_nxt = cy_nxt + sx;
        z_nxt  = z_nxt - ang;
      end
    end
  end

  assign in_ready = !valid_r || out_ready;

  // Valid bit of the stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // Payload of the stage.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cx_r    <= cx_nxt;
      cy_r    <= cy_nxt;
      z_r     <= z_nxt;
      flags_r <= in_flags;
    end
  end

  assign out_valid = valid_r;
  assign out_cx    = cx_r;
  assign out_cy    = cy_r;
  assign out_z     = z_r;
  assign out_flags = flags_r;

endmodule

FILE: hdl/pbd_back.sv
module pbd_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [pbd_pkg::ZW-1:0] in_z,
  input  pbd_pkg::flags_t               in_flags,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pbd_pkg::BEARING_W-1:0] bearing_deg,
  output logic                          same_point
);
  import pbd_pkg::*;

  logic                 v1_r, v2_r, v3_r;
  logic                 rdy1, rdy2, rdy3;
  logic [ANG_W-1:0]     ang;
  logic [PROD_W-1:0]    prod_nxt, prod_r;
  flags_t               flags1_r, flags2_r;
  logic [FOLD_W-1:0]    fold_nxt;
  logic [TENTHS_W-1:0]  tenths_r;
  logic [DIVP_W-1:0]    divp;
  logic [BEARING_W-1:0] bearing_nxt, bearing_r;
  logic                 same_r;

  // Ready ripples back so that bubbles close up behind a stalled result.
  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  // Stage one: clamp the angle and scale it to tenths of a degree.
  always_comb begin
    ang      = (in_flags.dx_zero || in_z[ZW-1]) ? '0 : in_z[ANG_W-1:0];
    prod_nxt = PROD_W'(ang) * PROD_W'(SCALE_TENTHS);
  end

  // Stage two: fold into the quadrant and add a quarter of a degree for rounding.
  always_comb begin
    unique case ({flags1_r.right, flags1_r.up})
      2'b11:   fold_nxt = HALF_Q + FOLD_W'(prod_r);
      2'b10:   fold_nxt = FOLD_180_Q + HALF_Q - FOLD_W'(prod_r);
      2'b01:   fold_nxt = FOLD_360_Q + HALF_Q - FOLD_W'(prod_r);
      default: fold_nxt = FOLD_180_Q + HALF_Q + FOLD_W'(prod_r);
    endcase
  end

  // Stage three: whole tenths divided by ten through the reciprocal.
  always_comb begin
    divp        = DIVP_W'(tenths_r) * DIVP_W'(DIV10_RECIP);
    bearing_nxt = flags2_r.same ? '0
                                : divp[DIV10_SHIFT +: BEARING_W];
  end

  // Valid bits of the three stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
    end
  end

  // Payload of the three stages.
  always_ff @(posedge clk) begin
    if (in_valid && rdy1) begin
      prod_r   <= prod_nxt;
      flags1_r <= in_flags;
    end
    if (v1_r && rdy2) begin
      tenths_r <= fold_nxt[FRAC_Q +: TENTHS_W];
      flags2_r <= flags1_r;
    end
    if (v2_r && rdy3) begin
      bearing_r <= bearing_nxt;
      same_r    <= flags2_r.same;
    end
  end

  assign out_valid   = v3_r;
  assign bearing_deg = bearing_r;
  assign same_point  = same_r;

endmodule

FILE: hdl/point_bearing_degrees.sv
// Channel   Direction  Transaction payload
// in_if     sink       from_x, from_y, to_x, to_y (COORD_BITS each)
// out_if    source     bearing_deg (9 bits), same_point (1 bit)
//
// One point pair is accepted per clock while the pipeline has room; each
// pair passes through one offset stage, twelve CORDIC stages of two
// micro-rotations each, then scale, fold and divide-by-ten stages.
// Reset is synchronous and active low and clears only the valid bits.
// A stalled output holds its result; each stage keeps taking data while it
// or a later stage has room, so bubbles close up under a stall.
module point_bearing_degrees #(
  parameter int COORD_BITS = pbd_pkg::COORD_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  pbd_in_if.sink    in_if,
  pbd_out_if.source out_if
);
  import pbd_pkg::*;

  localparam int CW = COORD_BITS + CORDIC_EXTRA;

  logic                 cv   [CORDIC_STAGES+1];
  logic                 crdy [CORDIC_STAGES+1];
  logic signed [CW-1:0] cx   [CORDIC_STAGES+1];
  logic signed [CW-1:0] cy   [CORDIC_STAGES+1];
  logic signed [ZW-1:0] cz   [CORDIC_STAGES+1];
  flags_t               cf   [CORDIC_STAGES+1];

  // Offsets, quadrant flags and CORDIC start values.
  pbd_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .from_x    (in_if.from_x),
    .from_y    (in_if.from_y),
    .to_x      (in_if.to_x),
    .to_y      (in_if.to_y),
    .out_valid (cv[0]),
    .out_ready (crdy[0]),
    .out_cx    (cx[0]),
    .out_cy    (cy[0]),
    .out_flags (cf[0])
  );

  assign cz[0] = '0;

  // CORDIC pipeline.
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    pbd_cordic_stage #(
      .COORD_BITS (COORD_BITS),
      .FIRST      (g * STEPS_PER_STAGE)
    ) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (cv[g]),
      .in_ready  (crdy[g]),
      .in_cx     (cx[g]),
      .in_cy     (cy[g]),
      .in_z      (cz[g]),
      .in_flags  (cf[g]),
      .out_valid (cv[g+1]),
      .out_ready (crdy[g+1]),
      .out_cx    (cx[g+1]),
      .out_cy    (cy[g+1]),
      .out_z     (cz[g+1]),
      .out_flags (cf[g+1])
    );
  end

  // Scale, quadrant fold and rounding.
  pbd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (cv[CORDIC_STAGES]),
    .in_ready    (crdy[CORDIC_STAGES]),
    .in_z        (cz[CORDIC_STAGES]),
    .in_flags    (cf[CORDIC_STAGES]),
    .out_valid   (out_if.valid),
    .out_ready   (out_if.ready),
    .bearing_deg (out_if.bearing_deg),
    .same_point  (out_if.same_point)
  );

endmodule

FILE: hdl/pbd_checker.sv
module pbd_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [pbd_pkg::BEARING_W-1:0] bearing_deg,
  input logic                          same_point
);
  import pbd_pkg::*;

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Result offered right after reset.");

  // With no result waiting, every stage has room for a new pair.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("Input stalled while the output stage is empty.");

  // Coincident points report a zero bearing.
  a_same_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && same_point) |-> (bearing_deg == '0))
    else $error("Coincident points gave a nonzero bearing.");

  // The bearing never passes a full turn.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (bearing_deg <= BEARING_W'(360)))
    else $error("Bearing above 360 degrees.");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(bearing_deg)
                                   && $stable(same_point)))
    else $error("Stalled result changed or vanished.");

endmodule

bind point_bearing_degrees pbd_checker u_pbd_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_if.valid),
  .in_ready    (in_if.ready),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .bearing_deg (out_if.bearing_deg),
  .same_point  (out_if.same_point)
);

FILE: dv/point_bearing_degrees_tb.sv
`timescale 1ns / 1ps

module point_bearing_degrees_tb;

  import pbd_pkg::*;

  localparam int COORD_W   = COORD_BITS_DEF;
  localparam int COORD_MAX = (1 << COORD_W) - 1;
  localparam int N_PROBES  = 20;
  localparam int N_CHUNKS  = 10;
  localparam int CHUNK_LEN = 113;
  localparam int LONG_HOLD = 80;
  localparam int SETTLE    = 40;

  typedef logic [COORD_W-1:0] coord_t;

  // One bearing transaction as it leaves the block.
  typedef struct packed {
    logic [BEARING_W-1:0] bearing;
    logic                 same;
  } heading_t;

  // A directed point pair; the bearing is typed in only where known is set.
  typedef struct packed {
    coord_t               fx;
    coord_t               fy;
    coord_t               tx;
    coord_t               ty;
    logic                 known;
    logic [BEARING_W-1:0] bearing;
    logic                 same;
  } probe_t;

  // atan(2^-i) in Q30 radians, truncated.
  localparam longint ARCTAN_Q30 [24] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
    64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
    64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
    64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
    64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
  };

  // Coincident points, the four axis directions, corners and near-axis pairs.
  probe_t probes [N_PROBES] = '{
    '{0,    0,    0,    0,    1'b1, 0,   1'b1},
    '{1023, 1023, 1023, 1023, 1'b1, 0,   1'b1},
    '{512,  300,  512,  300,  1'b1, 0,   1'b1},
    '{500,  600,  500,  100,  1'b1, 360, 1'b0},
    '{0,    1023, 0,    0,    1'b1, 360, 1'b0},
    '{1023, 1,    1023, 0,    1'b1, 360, 1'b0},
    '{1023, 0,    1023, 1023, 1'b1, 180, 1'b0},
    '{5,    5,    5,    6,    1'b1, 180, 1'b0},
    '{0,    512,  1023, 512,  1'b1, 90,  1'b0},
    '{100,  100,  101,  100,  1'b1, 90,  1'b0},
    '{1023, 0,    0,    0,    1'b1, 270, 1'b0},
    '{7,    900,  6,    900,  1'b1, 270, 1'b0},
    '{0,    1023, 1023, 0,    1'b0, 0,   1'b0},
    '{0,    0,    1023, 1023, 1'b0, 0,   1'b0},
    '{1023, 0,    0,    1023, 1'b0, 0,   1'b0},
    '{1023, 1023, 0,    0,    1'b0, 0,   1'b0},
    '{500,  1023, 501,  0,    1'b0, 0,   1'b0},
    '{501,  1023, 500,  0,    1'b0, 0,   1'b0},
    '{0,    500,  1023, 501,  1'b0, 0,   1'b0},
    '{10,   10,   11,   9,    1'b0, 0,   1'b0}
  };

  logic clk;
  logic rst_n;

  pbd_in_if #(.COORD_BITS(COORD_W)) pairs_if ();
  pbd_out_if                        heading_if ();

  point_bearing_degrees #(.COORD_BITS(COORD_W)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (pairs_if),
    .out_if (heading_if)
  );

  heading_t heading_q [$];
  int       mismatches  = 0;
  int       n_pairs     = 0;
  int       n_headings  = 0;
  int       n_coincide  = 0;
  bit       tx_idle     = 1'b0;
  bit       rx_idle     = 1'b0;
  bit       rx_hold_req = 1'b0;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Bearing from the observer to the target, in whole degrees clockwise from up.
  function automatic heading_t predict_heading(input coord_t fx, input coord_t fy,
                                               input coord_t tx, input coord_t ty);
    longint unsigned adx, ady, scaled, folded;
    longint          cx, cy, z, sx, sy;
    heading_t        h;
    h.bearing = '0;
    h.same    = 1'b0;
    if (fx == tx && fy == ty) begin
      h.same = 1'b1;
      return h;
    end
    adx = (fx > tx) ? longint'(fx) - longint'(tx) : longint'(tx) - longint'(fx);
    ady = (fy > ty) ? longint'(fy) - longint'(ty) : longint'(ty) - longint'(fy);
    z = 0;
    // Vectoring rotations drive the y term to zero; a pure vertical offset
    // has an angle of exactly zero.
    if (adx != 0) begin
      cx = longint'(ady << 24);
      cy = longint'(adx << 24);
      for (int i = 0; i < 24; i++) begin
        sx = cx >>> i;
        sy = cy >>> i;
        if (cy >= 0) begin
          cx = cx + sy;
          cy = cy - sx;
          z  = z + ARCTAN_Q30[i];
        end else begin
          cx = cx - sy;
          cy = cy + sx;
          z  = z - ARCTAN_Q30[i];
        end
      end
      if (z < 0) z = 0;
    end
    // Scale to tenths of a degree and fold into the quadrant.
    scaled = longint'(z) * 64'd573;
    if (fx < tx) begin
      folded = (fy > ty) ? scaled : (64'd1800 << 30) - scaled;
    end else begin
      folded = (fy > ty) ? (64'd3600 << 30) - scaled : (64'd1800 << 30) + scaled;
    end
    folded = (folded + (64'd5 << 29)) / (64'd10 << 30);
    h.bearing = folded[BEARING_W-1:0];
    return h;
  endfunction

  // Offer one pair and record what it should produce once it is accepted.
  task automatic offer_pair(input coord_t fx, input coord_t fy, input coord_t tx,
                            input coord_t ty, input heading_t want);
    int gap;
    gap = tx_idle ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      pairs_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pairs_if.valid  <= 1'b1;
    pairs_if.from_x <= fx;
    pairs_if.from_y <= fy;
    pairs_if.to_x   <= tx;
    pairs_if.to_y   <= ty;
    do @(posedge clk); while (!pairs_if.ready);
    heading_q.push_back(want);
    n_pairs++;
  endtask

  // Stop offering until every outstanding bearing has come back.
  task automatic drain_headings();
    pairs_if.valid <= 1'b0;
    do @(posedge clk); while (heading_q.size() != 0);
  endtask

  // Random pair, biased toward axes, diagonals, short offsets and coincidence.
  task automatic random_pair(output coord_t fx, output coord_t fy,
                             output coord_t tx, output coord_t ty);
    int a, b, d;
    a  = $urandom_range(0, COORD_MAX);
    b  = $urandom_range(0, COORD_MAX);
    fx = coord_t'(a);
    fy = coord_t'(b);
    tx = coord_t'($urandom_range(0, COORD_MAX));
    ty = coord_t'($urandom_range(0, COORD_MAX));
    case ($urandom_range(0, 9))
      5: begin
        tx = coord_t'($urandom_range((a < 3) ? 0 : a - 3,
                                     (a > COORD_MAX - 3) ? COORD_MAX : a + 3));
        ty = coord_t'($urandom_range((b < 3) ? 0 : b - 3,
                                     (b > COORD_MAX - 3) ? COORD_MAX : b + 3));
      end
      6: tx = fx;
      7: ty = fy;
      8: begin
        tx = fx;
        ty = fy;
      end
      9: begin
        d = $urandom_range(1, COORD_MAX / 2);
        if ($urandom_range(0, 1)) begin
          a  = $urandom_range(0, COORD_MAX - d);
          fx = coord_t'(a);
          tx = coord_t'(a + d);
        end else begin
          a  = $urandom_range(d, COORD_MAX);
          fx = coord_t'(a);
          tx = coord_t'(a - d);
        end
        if ($urandom_range(0, 1)) begin
          b  = $urandom_range(0, COORD_MAX - d);
          fy = coord_t'(b);
          ty = coord_t'(b + d);
        end else begin
          b  = $urandom_range(d, COORD_MAX);
          fy = coord_t'(b);
          ty = coord_t'(b - d);
        end
      end
      default: ;
    endcase
  endtask

  // Sender: reset, directed pairs, then random pairs in chunks.
  initial begin
    coord_t   fx, fy, tx, ty;
    heading_t want;
    rst_n           <= 1'b0;
    pairs_if.valid  <= 1'b0;
    pairs_if.from_x <= '0;
    pairs_if.from_y <= '0;
    pairs_if.to_x   <= '0;
    pairs_if.to_y   <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_PROBES; i++) begin
      if (probes[i].known) begin
        want.bearing = probes[i].bearing;
        want.same    = probes[i].same;
      end else begin
        want = predict_heading(probes[i].fx, probes[i].fy, probes[i].tx, probes[i].ty);
      end
      offer_pair(probes[i].fx, probes[i].fy, probes[i].tx, probes[i].ty, want);
    end
    drain_headings();

    for (int k = 0; k < N_CHUNKS; k++) begin
      tx_idle = (k % 4 == 0) || (k % 4 == 2);
      rx_idle = (k % 4 == 0) || (k % 4 == 3);
      // Back-to-back pairs against a long output stall fill the pipeline.
      if (k == 1) rx_hold_req = 1'b1;
      if (k == 6) drain_headings();
      for (int j = 0; j < CHUNK_LEN; j++) begin
        random_pair(fx, fy, tx, ty);
        offer_pair(fx, fy, tx, ty, predict_heading(fx, fy, tx, ty));
      end
    end
    pairs_if.valid <= 1'b0;

    while (heading_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    $display("Sent %0d point pairs (%0d directed) and checked %0d bearings, %0d coincident.",
             n_pairs, N_PROBES, n_headings, n_coincide);
    $display("Covered axis and corner cases, random idling, a long output stall and a drain.");
    if (mismatches == 0) begin
      $display("point_bearing_degrees_tb passed");
    end else begin
      $display("point_bearing_degrees_tb failed");
    end
    $finish;
  end

  // Receiver: random stalls per transaction, plus one long hold-off on request.
  initial begin
    int stall;
    heading_if.ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        heading_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        rx_hold_req = 1'b0;
      end
      stall = rx_idle ? $urandom_range(0, 6) : 0;
      if (stall > 0) begin
        heading_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      heading_if.ready <= 1'b1;
      do @(posedge clk); while (!heading_if.valid);
    end
  end

  // Compare each bearing transaction with the oldest outstanding prediction.
  always @(posedge clk) begin
    heading_t want;
    if (rst_n && heading_if.valid && heading_if.ready) begin
      if (heading_q.size() == 0) begin
        $display("%0t: unexpected bearing: expected none, actual %0d same %0b",
                 $time, heading_if.bearing_deg, heading_if.same_point);
        mismatches++;
      end else begin
        want = heading_q.pop_front();
        n_headings++;
        if (want.same) n_coincide++;
        if (heading_if.bearing_deg !== want.bearing) begin
          $display("%0t: bearing_deg mismatch: expected %0d, actual %0d",
                   $time, want.bearing, heading_if.bearing_deg);
          mismatches++;
        end
        if (heading_if.same_point !== want.same) begin
          $display("%0t: same_point mismatch: expected %0b, actual %0b",
                   $time, want.same, heading_if.same_point);
          mismatches++;
        end
      end
    end
  end

  // Watchdog for a hung handshake.
  initial begin
    #2ms;
    $display("point_bearing_degrees_tb failed");
    $finish;
  end

endmodule
